// File: rtl/sorted_priority_queue_core_defines.svh
// assertion helpers for the queue core rtl
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// checked on every edge once reset is released
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef struct packed {
        t_kind                     kind;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  priority_req;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0]  head_value;
        logic signed [DATA_W-1:0]  head_priority;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      is_empty;
        t_err                      error;
    } t_out_beat;

    // one stored pair
    typedef struct packed {
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  prio;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_cmd;

endpackage

// File: rtl/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_take,
    input  spq_pkg::t_entry    i_right,
    input  logic               i_occupied,
    input  logic               i_at_end,
    output spq_pkg::t_entry    o_entry,
    output logic               o_take
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_gt;

    // new pair outranks this slot
    assign w_gt   = i_new.prio > r_entry.prio;
    // slot at or after the insert point, or the first free slot
    assign o_take = i_occupied ? w_gt : i_at_end;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.insert && o_take) begin
            n_entry = i_left_take ? i_left : i_new;
        end else if (i_cmd.remove) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/sorted_priority_queue_core.sv
// Bounded sorted priority queue, highest priority at the head. Each input beat
// inserts a value/priority pair, removes the head, clears the queue or only
// queries it, and produces exactly one output beat describing the queue after
// the operation: head value and priority (zero when empty), entry count, empty
// flag and an error code (insert into a full queue is dropped, remove from an
// empty queue is ignored). Pairs of equal priority leave in arrival order.
// Storage is a row of CAPACITY cells; every cell compares the incoming
// priority against its own slot in parallel and takes its left neighbor,
// its right neighbor or the new pair, so all slots update at once. Throughput
// is one beat per clock while the output is not stalled; the output beat
// follows input acceptance in the next cycle, from the result register. The
// input stalls only while a finished output beat is itself stalled. There is
// no clearing pass after reset: slots past the count are never shown.
module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spq_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spq_pkg::t_out_beat o_out_data
);

    `include "sorted_priority_queue_core_defines.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // control state
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    spq_pkg::t_err      r_err;
    spq_pkg::t_err      n_err;
    logic               r_out_valid;
    logic               n_out_valid;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    spq_pkg::t_cell_cmd w_cmd;
    spq_pkg::t_entry    w_new;

    // cell row wiring
    spq_pkg::t_entry    w_entry [CAPACITY];
    logic               w_take  [CAPACITY];

    // accept whenever the result register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_new.value = i_in_data.value;
    assign w_new.prio  = i_in_data.priority_req;

    // decode the operation into a cell command, next count and error code
    always_comb begin
        n_count    = r_count;
        n_err      = spq_pkg::ERR_NONE;
        w_cmd      = '0;
        case (i_in_data.kind)
            spq_pkg::KIND_INSERT: begin
                if (w_full) begin
                    n_err = spq_pkg::ERR_FULL;
                end else begin
                    w_cmd.insert = w_accept;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            spq_pkg::KIND_REMOVE: begin
                if (w_empty) begin
                    n_err = spq_pkg::ERR_EMPTY;
                end else begin
                    w_cmd.remove = w_accept;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            spq_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // result beat stays valid until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= spq_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_count <= n_count;
                r_err   <= n_err;
            end
        end
    end

    // row of cells, slot 0 is the head; neighbors shift right on insert,
    // left on remove
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_take;

        if (g == 0) begin : g_head
            assign w_left      = w_entry[g];
            assign w_left_take = 1'b0;
        end else begin : g_body
            assign w_left      = w_entry[g-1];
            assign w_left_take = w_take[g-1];
        end

        // tail has no right neighbor; its slot becomes free on remove anyway
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_left_take (w_left_take),
            .i_right     (w_right),
            .i_occupied  (CNT_W'(g) < r_count),
            .i_at_end    (CNT_W'(g) == r_count),
            .o_entry     (w_entry[g]),
            .o_take      (w_take[g])
        );
    end

    // head fields read straight from cell 0; it holds while the beat is stalled
    assign o_out_valid              = r_out_valid;
    assign o_out_data.head_value    = w_empty ? '0 : w_entry[0].value;
    assign o_out_data.head_priority = w_empty ? '0 : w_entry[0].prio;
    assign o_out_data.entry_count   = spq_pkg::COUNT_OUT_W'(r_count);
    assign o_out_data.is_empty      = w_empty;
    assign o_out_data.error         = r_err;

    // count stays within the row of cells; unknown before the first reset edge
    `SPQ_ASSERT_ALWAYS(a_count_bound, i_clk, !i_rst_n || (r_count <= CNT_W'(CAPACITY)), "count above capacity")

    // a granted insert grows the queue by exactly one
    `SPQ_ASSERT(a_insert_grows, i_clk, i_rst_n, (w_accept && i_in_data.kind == spq_pkg::KIND_INSERT && !w_full) |=> (r_count == $past(r_count) + CNT_W'(1)), "insert did not grow count")

    // a full error only ever reports a full queue
    `SPQ_ASSERT(a_full_err, i_clk, i_rst_n, (o_out_valid && o_out_data.error == spq_pkg::ERR_FULL) |-> w_full, "full error with room left")

    // an empty error leaves the queue empty
    `SPQ_ASSERT(a_empty_err, i_clk, i_rst_n, (o_out_valid && o_out_data.error == spq_pkg::ERR_EMPTY) |-> o_out_data.is_empty, "empty error on non-empty queue")

endmodule

// File: test/sorted_priority_queue_core_check.sv
`timescale 1ns / 100ps

module sorted_priority_queue_core_check
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    // shadow copy of the sorted list, index 0 is the head
    t_entry    shadow_entries[$];
    t_out_beat due_results[$];
    t_out_beat want;
    int        fails = 0;

    // apply one input beat to the shadow list, return the head summary
    function automatic t_out_beat step_sorted_list(input t_in_beat b);
        t_out_beat r;
        t_entry    e;
        int        pos;
        int        i;
        r     = '0;
        r.error = ERR_NONE;
        case (b.kind)
            KIND_INSERT: begin
                if (shadow_entries.size() >= CAPACITY) begin
                    r.error = ERR_FULL;
                end else begin
                    pos = shadow_entries.size();
                    for (i = 0; i < shadow_entries.size(); i++) begin
                        if ($signed(b.priority_req) > $signed(shadow_entries[i].prio)) begin
                            pos = i;
                            break;
                        end
                    end
                    e.value = b.value;
                    e.prio  = b.priority_req;
                    shadow_entries.insert(pos, e);
                end
            end
            KIND_REMOVE: begin
                if (shadow_entries.size() == 0)
                    r.error = ERR_EMPTY;
                else
                    void'(shadow_entries.pop_front());
            end
            KIND_CLEAR: shadow_entries.delete();
            default: ;
        endcase
        if (shadow_entries.size() == 0) begin
            r.is_empty = 1'b1;
        end else begin
            r.head_value    = shadow_entries[0].value;
            r.head_priority = shadow_entries[0].prio;
        end
        r.entry_count = COUNT_OUT_W'(shadow_entries.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // output side first, before this edge's input beat is queued
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("output beat with no result due");
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (i_out_data.head_value !== want.head_value) begin
                        $error("head_value: expected %0d, got %0d",
                            want.head_value, i_out_data.head_value);
                        fails++;
                    end
                    if (i_out_data.head_priority !== want.head_priority) begin
                        $error("head_priority: expected %0d, got %0d",
                            want.head_priority, i_out_data.head_priority);
                        fails++;
                    end
                    if (i_out_data.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                            want.entry_count, i_out_data.entry_count);
                        fails++;
                    end
                    if (i_out_data.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0b, got %0b",
                            want.is_empty, i_out_data.is_empty);
                        fails++;
                    end
                    if (i_out_data.error !== want.error) begin
                        $error("error: expected %0d, got %0d",
                            want.error, i_out_data.error);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                due_results.push_back(step_sorted_list(i_in_data));
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
    end

endmodule

// File: test/sorted_priority_queue_core_test.sv
`timescale 1ns / 100ps

module sorted_priority_queue_core_test;
    import spq_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int ITEM_TOTAL   = 750;
    localparam int CYCLE_LIMIT  = 400000;
    // spare cycles after the last result catch strays
    localparam int DRAIN_CYCLES = 8;

    // stimulus flavor for one run of beats
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_data;

    int fail_count;
    int pending;
    int cycles     = 0;
    int sent       = 0;
    int stall_left = 0;
    int roll;
    // calm stretches: no input gaps and no new output stalls
    bit calm       = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sorted_priority_queue_core #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    sorted_priority_queue_core_check #(
        .CAPACITY (CAPACITY)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // hard stop in case the handshake hangs
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output back-pressure: mostly open, short stalls, now and then a long one
    always @(posedge clk) begin
        roll = $urandom_range(0, 99);
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (calm || roll < 65) begin
            out_stall <= 1'b0;
        end else if (roll < 93) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(8, 30);
        end
    end

    // idle cycles before the next input beat
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // priorities: many ties in a narrow band, extremes, sign boundary, full range
    function automatic logic [31:0] pick_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 32'($urandom_range(0, 4)) - 32'd2;
        if (r < 75)
            return $urandom();
        if (r < 90) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if ($urandom_range(0, 1))
            return 32'h8000_0000 + 32'($urandom_range(0, 3));
        return 32'h7fff_fffc + 32'($urandom_range(0, 3));
    endfunction

    // operation mix per mode; fill mode never clears so the queue reaches full
    function automatic t_kind pick_kind(input t_mode m);
        int r;
        r = $urandom_range(0, 99);
        case (m)
            MODE_FILL: begin
                if (r < 88) return KIND_INSERT;
                if (r < 93) return KIND_REMOVE;
                return KIND_QUERY;
            end
            MODE_DRAIN: begin
                if (r < 15) return KIND_INSERT;
                if (r < 90) return KIND_REMOVE;
                if (r < 98) return KIND_QUERY;
                return KIND_CLEAR;
            end
            default: begin
                if (r < 45) return KIND_INSERT;
                if (r < 85) return KIND_REMOVE;
                if (r < 95) return KIND_QUERY;
                return KIND_CLEAR;
            end
        endcase
    endfunction

    // drive one beat and hold it until it is taken
    task automatic send_beat(input t_kind k, input logic [31:0] v, input logic [31:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in_beat'{kind: k, value: v, priority_req: p};
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    initial begin
        t_mode mode;
        int    run_len;
        bit    first_run;

        first_run = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue: query, remove (flagged), clear
        send_beat(KIND_QUERY,  32'h5a5a_5a5a, 32'h7fff_ffff);
        send_beat(KIND_REMOVE, 32'hffff_ffff, 32'h8000_0000);
        send_beat(KIND_CLEAR,  32'h0000_0000, 32'h0000_0000);
        // extremes of value and priority, landing at the head, the tail and in the middle
        send_beat(KIND_INSERT, 32'h7fff_ffff, 32'h0000_0000);
        send_beat(KIND_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(KIND_INSERT, 32'h0000_0000, 32'h8000_0000);
        send_beat(KIND_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        // equal priorities queue up behind the earlier one
        send_beat(KIND_INSERT, 32'h0000_0011, 32'h0000_0000);
        send_beat(KIND_INSERT, 32'h0000_0022, 32'h0000_0000);
        // query with junk in the ignored fields
        send_beat(KIND_QUERY,  32'hffff_ffff, 32'h8000_0000);
        // pops come out in priority order, ties in arrival order
        repeat (4) send_beat(KIND_REMOVE, $urandom(), $urandom());
        // clear with entries held, then remove on the cleared queue
        send_beat(KIND_CLEAR,  $urandom(), $urandom());
        send_beat(KIND_REMOVE, $urandom(), $urandom());

        // random runs; the first one fills the queue and overflows it
        while (sent < ITEM_TOTAL) begin
            if (first_run) begin
                mode      = MODE_FILL;
                run_len   = 40;
                first_run = 1'b0;
            end else begin
                mode    = t_mode'($urandom_range(0, 2));
                run_len = $urandom_range(10, 60);
            end
            calm = ($urandom_range(0, 3) == 0);
            repeat (run_len) begin
                if (sent < ITEM_TOTAL)
                    send_beat(pick_kind(mode), $urandom(), pick_priority());
            end
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        // pending is registered, so advance the clock before looking at it
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sorted_priority_queue_core.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
test/sorted_priority_queue_core_check.sv
test/sorted_priority_queue_core_test.sv
